FILE: hw/rtl/cos_pkg.sv
// Shared widths, payload types and constants for the circle overlap separator.
package cos_pkg;

  localparam int unsigned FracBits = 8;
  localparam int unsigned PosBits  = 24;
  localparam int unsigned SizeBits = 12;

  // Centre differences, their magnitudes and the squared distance.
  localparam int unsigned DiffBits = PosBits + 2;
  localparam int unsigned MagBits  = PosBits + 1;
  localparam int unsigned Dist2Bits = 2 * MagBits + 1;

  // Roots and the radicand seen by the square root cells.
  localparam int unsigned RootBits = 21;
  localparam int unsigned RadBits  = 2 * RootBits;
  localparam int unsigned SqRemBits = RootBits + 2;
  localparam int unsigned SqSteps  = RootBits;

  // Push division: numerator, doubled distance and quotient.
  localparam int unsigned NumBits = 2 * RootBits + 1;
  localparam int unsigned DenBits = RootBits + 1;
  localparam int unsigned QuoBits = RootBits;
  localparam int unsigned DivSteps = QuoBits;

  localparam int unsigned InBits  = 4 * PosBits + 4 * SizeBits;
  localparam int unsigned OutBits = 4 * PosBits;
  localparam int unsigned FlagBits = 3;

  localparam int unsigned FlagCollided = 0;
  localparam int unsigned FlagCoincide = 1;
  localparam int unsigned FlagSaturated = 2;

  typedef struct packed {
    logic signed [PosBits-1:0] x1;
    logic signed [PosBits-1:0] y1;
    logic signed [PosBits-1:0] x2;
    logic signed [PosBits-1:0] y2;
  } pos_t;

  typedef struct packed {
    logic [RadBits-1:0]   rad;
    logic [SqRemBits-1:0] rem;
    logic [RootBits-1:0]  root;
  } sq_t;

  typedef struct packed {
    logic [DenBits-1:0] rem;
    logic [QuoBits-1:0] num;
    logic [DenBits-1:0] den;
    logic [QuoBits-1:0] q;
  } dv_t;

  typedef struct packed {
    pos_t                pos;
    logic                sx;
    logic                sy;
    logic [RootBits-1:0] ax;
    logic [RootBits-1:0] ay;
    logic                same;
    logic                far;
    logic [RadBits-1:0]  d2;
  } mid_t;

  typedef struct packed {
    pos_t pos;
    logic sx;
    logic sy;
    logic hit;
    logic same;
  } back_t;

endpackage

FILE: hw/rtl/cos_sqrt_cell.sv
// One digit step of the integer square root, registered.
module cos_sqrt_cell (
  input  logic         clk_i,
  input  logic         en_i,
  input  cos_pkg::sq_t d_i,
  output cos_pkg::sq_t q_o
);
  import cos_pkg::*;

  logic [SqRemBits+1:0] rem2;
  logic [SqRemBits+1:0] trial;
  sq_t                  step_d;
  sq_t                  step_q;

  always_comb begin
    rem2  = {d_i.rem, d_i.rad[RadBits-1 -: 2]};
    trial = {2'b00, d_i.root, 2'b01};
    step_d.rad = {d_i.rad[RadBits-3:0], 2'b00};
    if (rem2 >= trial) begin
      step_d.rem  = SqRemBits'(rem2 - trial);
      step_d.root = {d_i.root[RootBits-2:0], 1'b1};
    end else begin
      step_d.rem  = rem2[SqRemBits-1:0];
      step_d.root = {d_i.root[RootBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule

FILE: hw/rtl/cos_div_cell.sv
// One quotient bit of the restoring push division, registered.
module cos_div_cell (
  input  logic         clk_i,
  input  logic         en_i,
  input  cos_pkg::dv_t d_i,
  output cos_pkg::dv_t q_o
);
  import cos_pkg::*;

  logic [DenBits:0] trial;
  dv_t              step_d;
  dv_t              step_q;

  always_comb begin
    trial      = {d_i.rem, d_i.num[QuoBits-1]};
    step_d.num = {d_i.num[QuoBits-2:0], 1'b0};
    step_d.den = d_i.den;
    if (trial >= {1'b0, d_i.den}) begin
      step_d.rem = DenBits'(trial - {1'b0, d_i.den});
      step_d.q   = {d_i.q[QuoBits-2:0], 1'b1};
    end else begin
      step_d.rem = trial[DenBits-1:0];
      step_d.q   = {d_i.q[QuoBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      step_q <= step_d;
    end
  end

  assign q_o = step_q;

endmodule

FILE: hw/rtl/circle_overlap_separator.sv
// Top level of the circle overlap separator pipeline.
// Takes one box pair per cycle while the output is not stalled and returns one result
// per pair. The pipeline is two rows of 21 cells: one square root digit per cell for
// both radii and the centre distance, then one quotient bit per cell for the push on
// each axis, with three stages before, three between and one output register after.
// A stalled output holds the whole pipeline.
module circle_overlap_separator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  // first_x, first_y, first_width, first_height, second_x, second_y, second_width,
  // second_height
  input  logic [cos_pkg::InBits-1:0]  s_axis_tdata_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // new_first_x, new_first_y, new_second_x, new_second_y
  output logic [cos_pkg::OutBits-1:0] m_axis_tdata_o,
  // collided, centres_coincide, saturated
  output logic [cos_pkg::FlagBits-1:0] m_axis_tuser_o
);
  import cos_pkg::*;

  localparam int unsigned CentreShift = FracBits - 1;
  localparam int unsigned RadShift = 2 * FracBits - 2;

  logic adv;

  // Input fields.
  pos_t                 in_pos;
  logic [SizeBits-1:0]  w1, h1, w2, h2;
  logic signed [DiffBits-1:0] c1x, c1y, c2x, c2y, dx, dy;

  // Stage A.
  logic                 va_q;
  pos_t                 a_pos_q;
  logic                 a_sx_q, a_sy_q;
  logic [MagBits-1:0]   a_ax_q, a_ay_q;
  logic [RadBits-1:0]   a_rad1_q, a_rad2_q;
  logic [2*SizeBits:0]  s1, s2;

  // Stage B.
  logic                 vb_q;
  pos_t                 b_pos_q;
  logic                 b_sx_q, b_sy_q, b_same_q;
  logic [RootBits-1:0]  b_ax_q, b_ay_q;
  logic [2*MagBits-1:0] b_sqx_q, b_sqy_q;
  logic [RadBits-1:0]   b_rad1_q, b_rad2_q;

  // Stage C.
  logic                 vc_q;
  mid_t                 c_mid_q;
  logic [RadBits-1:0]   c_rad1_q, c_rad2_q;
  logic [Dist2Bits-1:0] dist2;

  // Square root row.
  sq_t  r1_s [SqSteps];
  sq_t  r2_s [SqSteps];
  sq_t  rd_s [SqSteps];
  mid_t mid_q [SqSteps];
  logic [SqSteps-1:0] vm_q;

  // Stages E, F, G.
  logic                 ve_q, vf_q, vg_q;
  mid_t                 e_mid_q, f_mid_q;
  logic [RootBits-1:0]  e_rsum_q, e_dist_q, f_dist_q, f_depth_q;
  logic [RadBits-1:0]   f_rsq_q;
  back_t                g_back_q;
  logic [NumBits-1:0]   g_numx_q, g_numy_q;
  logic [DenBits-1:0]   g_den_q;
  logic [NumBits-1:0]   numx, numy;

  // Division row.
  dv_t   dx_s [DivSteps];
  dv_t   dy_s [DivSteps];
  back_t back_q [DivSteps];
  logic [DivSteps-1:0] vd_q;

  // Output stage.
  logic                 vo_q;
  logic [OutBits-1:0]   o_data_q;
  logic [FlagBits-1:0]  o_flags_q;
  back_t                fin;
  logic signed [QuoBits:0]  px, py;
  logic signed [PosBits:0]  n1x, n1y, n2x, n2y;
  logic signed [PosBits-1:0] c1xo, c1yo, c2xo, c2yo;
  logic                 sat_any, push;

  function automatic logic signed [PosBits-1:0] clamp_pos(input logic signed [PosBits:0] v);
    logic signed [PosBits-1:0] r;
    if (v[PosBits] != v[PosBits-1]) begin
      r = v[PosBits] ? {1'b1, {(PosBits-1){1'b0}}} : {1'b0, {(PosBits-1){1'b1}}};
    end else begin
      r = v[PosBits-1:0];
    end
    return r;
  endfunction

  function automatic logic clips(input logic signed [PosBits:0] v);
    return v[PosBits] != v[PosBits-1];
  endfunction

  assign adv = !vo_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_comb begin
    in_pos.x1 = s_axis_tdata_i[0 +: PosBits];
    in_pos.y1 = s_axis_tdata_i[PosBits +: PosBits];
    w1        = s_axis_tdata_i[2*PosBits +: SizeBits];
    h1        = s_axis_tdata_i[2*PosBits+SizeBits +: SizeBits];
    in_pos.x2 = s_axis_tdata_i[2*PosBits+2*SizeBits +: PosBits];
    in_pos.y2 = s_axis_tdata_i[3*PosBits+2*SizeBits +: PosBits];
    w2        = s_axis_tdata_i[4*PosBits+2*SizeBits +: SizeBits];
    h2        = s_axis_tdata_i[4*PosBits+3*SizeBits +: SizeBits];
    c1x = DiffBits'(in_pos.x1) + $signed(DiffBits'({w1, {CentreShift{1'b0}}}));
    c1y = DiffBits'(in_pos.y1) + $signed(DiffBits'({h1, {CentreShift{1'b0}}}));
    c2x = DiffBits'(in_pos.x2) + $signed(DiffBits'({w2, {CentreShift{1'b0}}}));
    c2y = DiffBits'(in_pos.y2) + $signed(DiffBits'({h2, {CentreShift{1'b0}}}));
    dx  = c2x - c1x;
    dy  = c2y - c1y;
    s1  = (2*SizeBits+1)'(w1) * (2*SizeBits+1)'(w1)
        + (2*SizeBits+1)'(h1) * (2*SizeBits+1)'(h1);
    s2  = (2*SizeBits+1)'(w2) * (2*SizeBits+1)'(w2)
        + (2*SizeBits+1)'(h2) * (2*SizeBits+1)'(h2);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_pos_q  <= in_pos;
      a_sx_q   <= dx[DiffBits-1];
      a_sy_q   <= dy[DiffBits-1];
      a_ax_q   <= dx[DiffBits-1] ? MagBits'(-dx) : MagBits'(dx);
      a_ay_q   <= dy[DiffBits-1] ? MagBits'(-dy) : MagBits'(dy);
      a_rad1_q <= RadBits'({s1, {RadShift{1'b0}}});
      a_rad2_q <= RadBits'({s2, {RadShift{1'b0}}});

      b_pos_q  <= a_pos_q;
      b_sx_q   <= a_sx_q;
      b_sy_q   <= a_sy_q;
      b_same_q <= (a_ax_q == '0) && (a_ay_q == '0);
      b_ax_q   <= a_ax_q[RootBits-1:0];
      b_ay_q   <= a_ay_q[RootBits-1:0];
      b_sqx_q  <= a_ax_q * a_ax_q;
      b_sqy_q  <= a_ay_q * a_ay_q;
      b_rad1_q <= a_rad1_q;
      b_rad2_q <= a_rad2_q;

      c_mid_q.pos  <= b_pos_q;
      c_mid_q.sx   <= b_sx_q;
      c_mid_q.sy   <= b_sy_q;
      c_mid_q.ax   <= b_ax_q;
      c_mid_q.ay   <= b_ay_q;
      c_mid_q.same <= b_same_q;
      c_mid_q.far  <= |dist2[Dist2Bits-1:RadBits];
      c_mid_q.d2   <= dist2[RadBits-1:0];
      c_rad1_q     <= b_rad1_q;
      c_rad2_q     <= b_rad2_q;
    end
  end

  assign dist2 = Dist2Bits'(b_sqx_q) + Dist2Bits'(b_sqy_q);

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    sq_t r1_in, r2_in, rd_in;
    if (k == 0) begin : g_head
      always_comb begin
        r1_in = '{rad: c_rad1_q, rem: '0, root: '0};
        r2_in = '{rad: c_rad2_q, rem: '0, root: '0};
        rd_in = '{rad: c_mid_q.d2, rem: '0, root: '0};
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          mid_q[k] <= c_mid_q;
        end
      end
    end else begin : g_body
      always_comb begin
        r1_in = r1_s[k-1];
        r2_in = r2_s[k-1];
        rd_in = rd_s[k-1];
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          mid_q[k] <= mid_q[k-1];
        end
      end
    end
    cos_sqrt_cell u_r1 (.clk_i(clk_i), .en_i(adv), .d_i(r1_in), .q_o(r1_s[k]));
    cos_sqrt_cell u_r2 (.clk_i(clk_i), .en_i(adv), .d_i(r2_in), .q_o(r2_s[k]));
    cos_sqrt_cell u_rd (.clk_i(clk_i), .en_i(adv), .d_i(rd_in), .q_o(rd_s[k]));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_mid_q  <= mid_q[SqSteps-1];
      e_rsum_q <= r1_s[SqSteps-1].root + r2_s[SqSteps-1].root;
      e_dist_q <= rd_s[SqSteps-1].root;

      f_mid_q   <= e_mid_q;
      f_dist_q  <= e_dist_q;
      f_depth_q <= e_rsum_q - e_dist_q;
      f_rsq_q   <= e_rsum_q * e_rsum_q;

      g_back_q.pos  <= f_mid_q.pos;
      g_back_q.sx   <= f_mid_q.sx;
      g_back_q.sy   <= f_mid_q.sy;
      g_back_q.same <= f_mid_q.same;
      g_back_q.hit  <= !f_mid_q.far && (f_mid_q.d2 <= f_rsq_q);
      g_numx_q      <= numx;
      g_numy_q      <= numy;
      g_den_q       <= {f_dist_q, 1'b0};
    end
  end

  // The magnitude never exceeds the distance on a hit, so its low bits suffice.
  assign numx = NumBits'(f_mid_q.ax) * NumBits'(f_depth_q) + NumBits'(f_dist_q);
  assign numy = NumBits'(f_mid_q.ay) * NumBits'(f_depth_q) + NumBits'(f_dist_q);

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    dv_t x_in, y_in;
    if (k == 0) begin : g_head
      always_comb begin
        x_in = '{rem: g_numx_q[NumBits-1 -: DenBits], num: g_numx_q[QuoBits-1:0],
                 den: g_den_q, q: '0};
        y_in = '{rem: g_numy_q[NumBits-1 -: DenBits], num: g_numy_q[QuoBits-1:0],
                 den: g_den_q, q: '0};
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          back_q[k] <= g_back_q;
        end
      end
    end else begin : g_body
      always_comb begin
        x_in = dx_s[k-1];
        y_in = dy_s[k-1];
      end
      always_ff @(posedge clk_i) begin
        if (adv) begin
          back_q[k] <= back_q[k-1];
        end
      end
    end
    cos_div_cell u_dx (.clk_i(clk_i), .en_i(adv), .d_i(x_in), .q_o(dx_s[k]));
    cos_div_cell u_dy (.clk_i(clk_i), .en_i(adv), .d_i(y_in), .q_o(dy_s[k]));
  end

  always_comb begin
    fin  = back_q[DivSteps-1];
    px   = fin.sx ? -$signed({1'b0, dx_s[DivSteps-1].q}) : $signed({1'b0, dx_s[DivSteps-1].q});
    py   = fin.sy ? -$signed({1'b0, dy_s[DivSteps-1].q}) : $signed({1'b0, dy_s[DivSteps-1].q});
    n1x  = (PosBits+1)'(fin.pos.x1) - (PosBits+1)'(px);
    n1y  = (PosBits+1)'(fin.pos.y1) - (PosBits+1)'(py);
    n2x  = (PosBits+1)'(fin.pos.x2) + (PosBits+1)'(px);
    n2y  = (PosBits+1)'(fin.pos.y2) + (PosBits+1)'(py);
    push = fin.hit && !fin.same;
    c1xo = push ? clamp_pos(n1x) : fin.pos.x1;
    c1yo = push ? clamp_pos(n1y) : fin.pos.y1;
    c2xo = push ? clamp_pos(n2x) : fin.pos.x2;
    c2yo = push ? clamp_pos(n2y) : fin.pos.y2;
    sat_any = push && (clips(n1x) || clips(n1y) || clips(n2x) || clips(n2y));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_data_q <= {c2yo, c2xo, c1yo, c1xo};
      o_flags_q[FlagCollided]  <= fin.hit;
      o_flags_q[FlagCoincide]  <= fin.hit && fin.same;
      o_flags_q[FlagSaturated] <= sat_any;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vm_q <= '0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
      vg_q <= 1'b0;
      vd_q <= '0;
      vo_q <= 1'b0;
    end else if (adv) begin
      va_q <= s_axis_tvalid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vm_q <= {vm_q[SqSteps-2:0], vc_q};
      ve_q <= vm_q[SqSteps-1];
      vf_q <= ve_q;
      vg_q <= vf_q;
      vd_q <= {vd_q[DivSteps-2:0], vg_q};
      vo_q <= vd_q[DivSteps-1];
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = o_data_q;
  assign m_axis_tuser_o  = o_flags_q;

endmodule

FILE: hw/rtl/cos_checker.sv
// Port-level checks for the circle overlap separator, bound to the top level.
module cos_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [cos_pkg::OutBits-1:0]  m_axis_tdata_o,
  input logic [cos_pkg::FlagBits-1:0] m_axis_tuser_o
);
  import cos_pkg::*;

  // A stalled item keeps its data and flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled output item changed");

  // Coincident centres are only reported for a collision.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[FlagCoincide] |-> m_axis_tuser_o[FlagCollided])
    else $error("coincident centres without collision");

  // No push is applied for coincident centres, so nothing can clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[FlagCoincide] |-> !m_axis_tuser_o[FlagSaturated])
    else $error("saturation with coincident centres");

  // Positions pass through untouched without a collision, so nothing can clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[FlagCollided] |-> !m_axis_tuser_o[FlagSaturated])
    else $error("saturation without collision");

endmodule

bind circle_overlap_separator cos_checker u_cos_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

FILE: verif/tb_top.sv
// Self-checking testbench for the circle overlap separator stream pipeline.
module tb_top;
  import cos_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned TailItems  = 120;
  localparam int unsigned RandItems  = 1150;

  typedef struct {
    logic [OutBits-1:0]  pos;
    logic [FlagBits-1:0] flags;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [InBits-1:0] s_data = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [OutBits-1:0] m_data;
  logic [FlagBits-1:0] m_user;

  logic [InBits-1:0] pending_boxes[$];
  bit                pending_drain[$];
  outcome_t          resolved_q[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned s_gap = 0;
  int unsigned m_gap = 0;
  int unsigned n_hits = 0;
  int unsigned n_same = 0;
  int unsigned n_sat = 0;
  int unsigned n_out = 0;
  bit holding = 1'b0;

  circle_overlap_separator DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready), .s_axis_tdata_i(s_data),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  initial forever #4 clk = ~clk;

  function automatic logic [63:0] root_floor(logic [127:0] n);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if ({64'd0, t} * {64'd0, t} <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] half_diag(logic [63:0] w, logic [63:0] h);
    logic [127:0] n;
    n = {64'd0, (w * w + h * h)} << (2 * FracBits - 2);
    return root_floor(n);
  endfunction

  function automatic longint push_len(longint diff, logic [63:0] depth, logic [63:0] dlen);
    logic [127:0] mag;
    logic [127:0] q;
    mag = diff < 0 ? 128'(-diff) : 128'(diff);
    q = (mag * {64'd0, depth} + {64'd0, dlen}) / {63'd0, dlen, 1'b0};
    return diff < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint clamp_pos(longint v, inout bit sat);
    longint hi;
    hi = (longint'(1) <<< (PosBits - 1)) - 1;
    if (v > hi) begin sat = 1'b1; return hi; end
    if (v < -hi - 1) begin sat = 1'b1; return -hi - 1; end
    return v;
  endfunction

  function automatic outcome_t resolve(logic [InBits-1:0] it);
    logic signed [PosBits-1:0] tx1, ty1, tx2, ty2;
    longint x1, y1, x2, y2, dx, dy, px, py, n1x, n1y, n2x, n2y;
    logic [63:0] w1, h1, w2, h2, ax, ay, rsum, dlen;
    logic [127:0] d2;
    bit hit, same, sat;
    outcome_t o;
    tx1 = it[23:0]; ty1 = it[47:24]; tx2 = it[95:72]; ty2 = it[119:96];
    x1 = tx1; y1 = ty1; x2 = tx2; y2 = ty2;
    w1 = it[59:48]; h1 = it[71:60]; w2 = it[131:120]; h2 = it[143:132];
    dx = (x2 + longint'(w2 << (FracBits - 1))) - (x1 + longint'(w1 << (FracBits - 1)));
    dy = (y2 + longint'(h2 << (FracBits - 1))) - (y1 + longint'(h1 << (FracBits - 1)));
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    rsum = half_diag(w1, h1) + half_diag(w2, h2);
    d2 = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
    hit = d2 <= {64'd0, rsum} * {64'd0, rsum};
    same = 1'b0; sat = 1'b0;
    n1x = x1; n1y = y1; n2x = x2; n2y = y2;
    if (hit) begin
      if (ax == 0 && ay == 0) begin
        same = 1'b1;
      end else begin
        dlen = root_floor(d2);
        px = push_len(dx, rsum - dlen, dlen);
        py = push_len(dy, rsum - dlen, dlen);
        n1x = clamp_pos(x1 - px, sat);
        n1y = clamp_pos(y1 - py, sat);
        n2x = clamp_pos(x2 + px, sat);
        n2y = clamp_pos(y2 + py, sat);
      end
    end
    o.pos = {n2y[23:0], n2x[23:0], n1y[23:0], n1x[23:0]};
    o.flags = '0;
    o.flags[FlagCollided] = hit;
    o.flags[FlagCoincide] = same;
    o.flags[FlagSaturated] = sat;
    return o;
  endfunction

  function automatic logic [InBits-1:0] pack_boxes(longint x1, longint y1, int w1, int h1,
                                                  longint x2, longint y2, int w2, int h2);
    logic [23:0] a, b, c, d;
    a = x1[23:0]; b = y1[23:0]; c = x2[23:0]; d = y2[23:0];
    return {h2[11:0], w2[11:0], d, c, h1[11:0], w1[11:0], b, a};
  endfunction

  function automatic longint fit_pos(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  // Most random pairs are placed close together so that the push path is exercised.
  function automatic logic [InBits-1:0] random_pair();
    int unsigned pick;
    int w1, h1, w2, h2;
    longint x1, y1, x2, y2, span;
    logic [InBits-1:0] raw;
    pick = $urandom_range(0, 99);
    w1 = $urandom_range(0, 4095); h1 = $urandom_range(0, 4095);
    w2 = $urandom_range(0, 4095); h2 = $urandom_range(0, 4095);
    if (pick < 10) begin
      raw = InBits'({$urandom, $urandom, $urandom, $urandom, $urandom});
      return raw;
    end
    if (pick < 20) begin
      x1 = $urandom_range(0, 1) ? 64'sd8388607 - $urandom_range(0, 1 << 21)
                                : -64'sd8388608 + $urandom_range(0, 1 << 21);
      y1 = $urandom_range(0, 1) ? 64'sd8388607 - $urandom_range(0, 1 << 21)
                                : -64'sd8388608 + $urandom_range(0, 1 << 21);
    end else begin
      x1 = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
      y1 = longint'($urandom_range(0, 1 << 23)) - (1 << 22);
    end
    if (pick < 30) begin
      x2 = fit_pos(x1 + longint'(w1 - w2) * 128);
      y2 = fit_pos(y1 + longint'(h1 - h2) * 128);
    end else begin
      span = pick < 70 ? (1 << 20) : (1 << 16);
      x2 = fit_pos(x1 + longint'($urandom_range(0, 2 * span)) - span);
      y2 = fit_pos(y1 + longint'($urandom_range(0, 2 * span)) - span);
    end
    return pack_boxes(x1, y1, w1, h1, x2, y2, w2, h2);
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("error at cycle %0d: %s got %h expected %h", cycles, what, got, want);
  endtask

  // Sender: bursts of idle cycles, and an optional hold until the pipeline has drained.
  always @(posedge clk) begin
    if (rst_n && (!s_valid || s_ready)) begin
      if (s_gap != 0) s_gap--;
      else if (pending_boxes.size() > TailItems && $urandom_range(0, 9) == 0)
        s_gap = $urandom_range(1, 17);
      // An item taken at this edge may not be in the expected queue yet.
      if (pending_boxes.size() != 0 && pending_drain[0] &&
          (resolved_q.size() != 0 || s_valid))
        holding = 1'b1;
      else
        holding = 1'b0;
      if (pending_boxes.size() != 0 && s_gap == 0 && !holding) begin
        s_data <= pending_boxes.pop_front();
        void'(pending_drain.pop_front());
        s_valid <= 1'b1;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (m_gap != 0) begin
        m_gap--;
        m_ready <= 1'b0;
      end else if (pending_boxes.size() > TailItems && $urandom_range(0, 9) == 0) begin
        m_gap = $urandom_range(1, 17);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && s_valid && s_ready) resolved_q.push_back(resolve(s_data));
    if (rst_n && m_valid && m_ready) begin
      n_out++;
      if (resolved_q.size() == 0) begin
        report("unexpected result", m_data[63:0], 64'd0);
      end else begin
        want = resolved_q.pop_front();
        if (want.flags[FlagCollided]) n_hits++;
        if (want.flags[FlagCoincide]) n_same++;
        if (want.flags[FlagSaturated]) n_sat++;
        if (m_user[FlagCollided] !== want.flags[FlagCollided])
          report("collided", 64'(m_user[FlagCollided]), 64'(want.flags[FlagCollided]));
        if (m_user[FlagCoincide] !== want.flags[FlagCoincide])
          report("centres_coincide", 64'(m_user[FlagCoincide]),
                 64'(want.flags[FlagCoincide]));
        if (m_user[FlagSaturated] !== want.flags[FlagSaturated])
          report("saturated", 64'(m_user[FlagSaturated]), 64'(want.flags[FlagSaturated]));
        if (m_data[23:0] !== want.pos[23:0])
          report("new_first_x", 64'(m_data[23:0]), 64'(want.pos[23:0]));
        if (m_data[47:24] !== want.pos[47:24])
          report("new_first_y", 64'(m_data[47:24]), 64'(want.pos[47:24]));
        if (m_data[71:48] !== want.pos[71:48])
          report("new_second_x", 64'(m_data[71:48]), 64'(want.pos[71:48]));
        if (m_data[95:72] !== want.pos[95:72])
          report("new_second_y", 64'(m_data[95:72]), 64'(want.pos[95:72]));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("circle_overlap_separator: mismatch");
      $finish;
    end
  end

  task automatic add_pair(logic [InBits-1:0] it, bit drain);
    pending_boxes.push_back(it);
    pending_drain.push_back(drain);
  endtask

  initial begin
    // Directed pairs: empty boxes, full-size boxes, range extremes, equal centres,
    // far apart pairs and pushes that clamp at both ends of the range.
    add_pair(pack_boxes(0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
    add_pair(pack_boxes(0, 0, 4095, 4095, 0, 0, 4095, 4095), 1'b0);
    add_pair(pack_boxes(0, 0, 4095, 0, 256, 0, 4093, 0), 1'b0);
    add_pair(pack_boxes(0, 0, 10, 10, 512, 0, 10, 10), 1'b0);
    add_pair(pack_boxes(0, 0, 10, 10, 0, 768, 10, 10), 1'b0);
    add_pair(pack_boxes(0, 0, 1, 1, 64'sd8388607, 64'sd8388607, 1, 1), 1'b0);
    add_pair(pack_boxes(-64'sd8388608, -64'sd8388608, 0, 0, 64'sd8388607, 64'sd8388607,
                        4095, 4095), 1'b0);
    add_pair(pack_boxes(64'sd8388607, 64'sd8388607, 4095, 4095, 64'sd8388000, 64'sd8388000,
                        4095, 4095), 1'b0);
    add_pair(pack_boxes(-64'sd8388608, -64'sd8388608, 4095, 4095, -64'sd8388000,
                        -64'sd8388000, 4095, 4095), 1'b0);
    add_pair(pack_boxes(-64'sd8388608, 0, 4095, 4095, -64'sd8388608 + 100, 0, 4095, 4095),
             1'b0);
    add_pair(pack_boxes(100, -200, 20, 30, 100 + 10 * 128, -200 + 20 * 128, 0, 10), 1'b0);
    add_pair(pack_boxes(-5000, 7000, 4095, 1, 5000, -7000, 3, 4095), 1'b0);
    add_pair(pack_boxes(0, 0, 3, 4, 1280, 0, 0, 0), 1'b0);
    add_pair(pack_boxes(64'sd8388607, -64'sd8388608, 4095, 4095, 64'sd8388607,
                        -64'sd8388608, 0, 0), 1'b0);
    for (int i = 0; i < RandItems; i++) add_pair(random_pair(), i == RandItems / 2);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_boxes.size() != 0 || s_valid) @(posedge clk);
    while (resolved_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    $display("checked %0d results: %0d collided, %0d with equal centres, %0d clamped",
             n_out, n_hits, n_same, n_sat);
    $display("random idling on both sides, one hold until drained, no idling at the end");
    if (errors == 0) begin
      $display("circle_overlap_separator: match");
    end else begin
      $display("circle_overlap_separator: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/cos_pkg.sv
hw/rtl/cos_sqrt_cell.sv
hw/rtl/cos_div_cell.sv
hw/rtl/circle_overlap_separator.sv
hw/rtl/cos_checker.sv
verif/tb_top.sv
